// ===== rtl/core/cfli_pkg.sv =====
// Shared constants for the coalescing free-list insert core and its checker.
// No dependencies.
`default_nettype none

package cfli_pkg;

  // Default table geometry.
  localparam int DEF_TABLE_DEPTH   = 64;
  localparam int DEF_ADDRESS_WIDTH = 32;

  // Result beat layout, lowest bit first, padded to whole bytes.
  localparam int OUT_MB_BIT  = 0;
  localparam int OUT_MA_BIT  = 1;
  localparam int OUT_FULL_BIT = 2;
  localparam int OUT_CNT_LSB = 3;
  localparam int OUT_CNT_W   = 7;
  localparam int OUT_USED_W  = OUT_CNT_LSB + OUT_CNT_W;
  localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== rtl/core/coalescing_free_list_insert_core.sv =====
// Top level of the address-ordered free list with coalescing.
// Depends on cfli_pkg for default geometry and the result beat layout.
`default_nettype none

// Keeps up to TABLE_DEPTH free blocks (address, size) sorted by address in a
// single-port-write table RAM with a registered read. Each input beat returns
// one block; it is merged with its lower and/or upper neighbor when they touch,
// otherwise inserted in order, or dropped with table_full set when the table
// is full. For each beat, a linear scan of the table reads one entry per
// cycle up to the insertion point, then the entries behind it are moved one
// per cycle (up for an insert, down for a merge on both sides); one shared
// adder forms block ends and merged sizes.
// The core takes no new input beat until the current one is finished, but a
// finished result waiting in the output register does not hold off the next
// input beat.
module coalescing_free_list_insert_core
  import cfli_pkg::*;
#(
  parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
  parameter int ADDRESS_WIDTH = DEF_ADDRESS_WIDTH,
  localparam int InDataW      = ((2 * ADDRESS_WIDTH + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata: block_address, block_size, zero pad
  input  wire logic [InDataW-1:0]    in_tdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // out_tdata: merged_below, merged_above, table_full, entry_count[6:0], zero pad
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready
);

  localparam int AW = ADDRESS_WIDTH;
  localparam int EW = 2 * AW;
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SCAN   = 4'd1;
  localparam logic [3:0] ST_DECIDE = 4'd2;
  localparam logic [3:0] ST_SUM1   = 4'd3;
  localparam logic [3:0] ST_SUM2   = 4'd4;
  localparam logic [3:0] ST_UPD    = 4'd5;
  localparam logic [3:0] ST_SHDN   = 4'd6;
  localparam logic [3:0] ST_SHUP   = 4'd7;
  localparam logic [3:0] ST_INS    = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  // Table RAM, entry packed as {size, address}.
  logic [EW-1:0] mem [TABLE_DEPTH];
  logic [EW-1:0] rd_q;
  logic [IW-1:0] rd_idx;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [EW-1:0] wr_data;

  // Control state.
  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          mb_r, mb_nxt;
  logic          ma_r, ma_nxt;
  logic          full_r, full_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Payload state.
  logic [AW-1:0] addr_r, addr_nxt;
  logic [AW-1:0] size_r, size_nxt;
  logic [AW-1:0] end_r, end_nxt;
  logic [AW-1:0] acc_r, acc_nxt;
  logic [EW-1:0] prev_r, prev_nxt;
  logic [EW-1:0] above_r, above_nxt;
  logic [OUT_USED_W-1:0] out_r, out_nxt;

  // Shared adder.
  logic [AW-1:0] add_a, add_b, add_y;

  // Helpers.
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] prev_addr, prev_size, above_addr, above_size;
  logic [AW-1:0] in_addr, in_size;
  logic [CW:0]   idx_p1, idx_p2, pos_p1, n_ext, idx_ext;
  logic [CW-1:0] idx_m1, idx_m2, n_m1, pos_m1;
  logic [CW+OUT_CNT_W-1:0] cnt_ext;

  assign rd_addr    = rd_q[AW-1:0];
  assign prev_addr  = prev_r[AW-1:0];
  assign prev_size  = prev_r[EW-1:AW];
  assign above_addr = above_r[AW-1:0];
  assign above_size = above_r[EW-1:AW];
  assign in_addr    = in_tdata[AW-1:0];
  assign in_size    = in_tdata[EW-1:AW];

  assign idx_ext = {1'b0, idx_r};
  assign n_ext   = {1'b0, n_r};
  assign idx_p1  = idx_ext + (CW+1)'(1);
  assign idx_p2  = idx_ext + (CW+1)'(2);
  assign pos_p1  = {1'b0, pos_r} + (CW+1)'(1);
  assign idx_m1  = idx_r - CW'(1);
  assign idx_m2  = idx_r - CW'(2);
  assign n_m1    = n_r - CW'(1);
  assign pos_m1  = pos_r - CW'(1);

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_q <= mem[rd_idx];
  end

  // Shared adder operand selection.
  always_comb begin
    add_a = prev_addr;
    add_b = prev_size;
    unique case (state_r)
      ST_IDLE: begin
        add_a = in_addr;
        add_b = in_size;
      end
      ST_SUM1: begin
        add_a = mb_r ? prev_size : above_size;
        add_b = size_r;
      end
      ST_SUM2: begin
        add_a = acc_r;
        add_b = above_size;
      end
      default: begin
        add_a = prev_addr;
        add_b = prev_size;
      end
    endcase
  end
  assign add_y = add_a + add_b;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    mb_nxt        = mb_r;
    ma_nxt        = ma_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r;
    addr_nxt      = addr_r;
    size_nxt      = size_r;
    end_nxt       = end_r;
    acc_nxt       = acc_r;
    prev_nxt      = prev_r;
    above_nxt     = above_r;
    out_nxt       = out_r;
    rd_idx        = '0;
    wr_en         = 1'b0;
    wr_idx        = '0;
    wr_data       = rd_q;
    in_tready     = 1'b0;

    // A waiting result leaves once taken.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        // Read entry 0 so the scan starts with data in hand.
        in_tready = 1'b1;
        rd_idx    = '0;
        if (in_tvalid) begin
          addr_nxt  = in_addr;
          size_nxt  = in_size;
          end_nxt   = add_y;
          idx_nxt   = '0;
          mb_nxt    = 1'b0;
          ma_nxt    = 1'b0;
          full_nxt  = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // rd_q holds entry idx_r; walk past entries at or below the address.
        rd_idx = idx_p1[IW-1:0];
        if (idx_r < n_r && rd_addr <= addr_r) begin
          prev_nxt = rd_q;
          idx_nxt  = idx_p1[CW-1:0];
        end else begin
          above_nxt = rd_q;
          pos_nxt   = idx_r;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // Neighbor tests; also prime the read for an upward shift.
        rd_idx = n_m1[IW-1:0];
        mb_nxt = (pos_r != '0) && (add_y == addr_r);
        ma_nxt = (pos_r < n_r) && (above_addr == end_r);
        idx_nxt = n_r;
        if (mb_nxt || ma_nxt) begin
          state_nxt = ST_SUM1;
        end else if (n_r >= CW'(TABLE_DEPTH)) begin
          full_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else if (pos_r == n_r) begin
          state_nxt = ST_INS;
        end else begin
          state_nxt = ST_SHUP;
        end
      end
      ST_SUM1: begin
        acc_nxt   = add_y;
        state_nxt = (mb_r && ma_r) ? ST_SUM2 : ST_UPD;
      end
      ST_SUM2: begin
        acc_nxt   = add_y;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        // Write the merged entry; a merge on both sides then closes the gap.
        wr_en  = 1'b1;
        rd_idx = pos_p1[IW-1:0];
        if (mb_r) begin
          wr_idx  = pos_m1[IW-1:0];
          wr_data = {acc_r, prev_addr};
        end else begin
          wr_idx  = pos_r[IW-1:0];
          wr_data = {acc_r, addr_r};
        end
        idx_nxt = pos_r;
        if (mb_r && ma_r) begin
          n_nxt     = n_m1;
          state_nxt = (pos_p1 < n_ext) ? ST_SHDN : ST_DONE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SHDN: begin
        // rd_q holds entry idx_r + 1; move it down one place.
        wr_en   = 1'b1;
        wr_idx  = idx_r[IW-1:0];
        wr_data = rd_q;
        rd_idx  = idx_p2[IW-1:0];
        idx_nxt = idx_p1[CW-1:0];
        if (idx_p1 == n_ext) begin
          state_nxt = ST_DONE;
        end
      end
      ST_SHUP: begin
        // rd_q holds entry idx_r - 1; move it up one place.
        wr_en   = 1'b1;
        wr_idx  = idx_r[IW-1:0];
        wr_data = rd_q;
        rd_idx  = idx_m2[IW-1:0];
        idx_nxt = idx_m1;
        if (idx_m1 == pos_r) begin
          state_nxt = ST_INS;
        end
      end
      ST_INS: begin
        wr_en     = 1'b1;
        wr_idx    = pos_r[IW-1:0];
        wr_data   = {size_r, addr_r};
        n_nxt     = n_r + CW'(1);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || out_tready) begin
          out_nxt[OUT_MB_BIT]   = mb_r;
          out_nxt[OUT_MA_BIT]   = ma_r;
          out_nxt[OUT_FULL_BIT] = full_r;
          out_nxt[OUT_CNT_LSB +: OUT_CNT_W] = cnt_ext[OUT_CNT_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign cnt_ext = {{OUT_CNT_W{1'b0}}, n_r};

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    pos_r   <= pos_nxt;
    mb_r    <= mb_nxt;
    ma_r    <= ma_nxt;
    full_r  <= full_nxt;
    addr_r  <= addr_nxt;
    size_r  <= size_nxt;
    end_r   <= end_nxt;
    acc_r   <= acc_nxt;
    prev_r  <= prev_nxt;
    above_r <= above_nxt;
    out_r   <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, out_r};

endmodule

`default_nettype wire

// ===== rtl/core/cfli_checker.sv =====
// Port-level checker for the coalescing free-list insert core, with its bind.
// Depends on cfli_pkg for the result beat layout.
`default_nettype none

module cfli_checker
  import cfli_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready
);

  logic [OUT_CNT_W-1:0] cnt;
  assign cnt = out_tdata[OUT_CNT_LSB +: OUT_CNT_W];

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // A dropped block never reports a merge.
  a_full_no_merge: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_FULL_BIT] |->
      !out_tdata[OUT_MB_BIT] && !out_tdata[OUT_MA_BIT])
    else $error("table_full reported together with a merge");

  // One block at a time: an accepted beat closes the input for the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a block is in progress");

  // The count never exceeds the table depth when it fits the field.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (TABLE_DEPTH > 127) || (32'(cnt) <= 32'(TABLE_DEPTH)))
    else $error("entry_count above table depth");

endmodule

bind coalescing_free_list_insert_core cfli_checker #(
  .TABLE_DEPTH(TABLE_DEPTH)
) u_cfli_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire

// ===== test/coalescing_free_list_insert_checker.sv =====
// Checker for the coalescing free-list insert core: watches both streams,
// keeps its own sorted free table and compares every result beat.
// Depends on cfli_pkg for the geometry and the result beat layout.
`default_nettype none

module coalescing_free_list_insert_checker
  import cfli_pkg::*;
#(
  parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
  parameter int ADDRESS_WIDTH = DEF_ADDRESS_WIDTH,
  localparam int InDataW      = ((2 * ADDRESS_WIDTH + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata: block_address, block_size, zero pad
  input  wire logic [InDataW-1:0]    in_tdata,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  // out_tdata: merged_below, merged_above, table_full, entry_count[6:0], zero pad
  input  wire logic [OUT_DATA_W-1:0] out_tdata,
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  output int                         mismatch_count,
  output int                         outstanding
);

  typedef struct packed {
    logic                 below;
    logic                 above;
    logic                 full;
    logic [OUT_CNT_W-1:0] count;
  } outcome_t;

  // Free table as the core should hold it, sorted by ascending address.
  logic [ADDRESS_WIDTH-1:0] free_base [TABLE_DEPTH];
  logic [ADDRESS_WIDTH-1:0] free_len  [TABLE_DEPTH];
  int                       free_used;

  // Outcomes of accepted blocks whose result beat has not arrived yet.
  outcome_t                 pending_outcomes [$];

  // Returns one block to the table and works out the result it must produce.
  function automatic outcome_t coalesce_block(input logic [ADDRESS_WIDTH-1:0] addr,
                                              input logic [ADDRESS_WIDTH-1:0] len);
    outcome_t                 res;
    logic [ADDRESS_WIDTH-1:0] blk_end;
    logic [ADDRESS_WIDTH-1:0] low_end;
    int                       n;
    int                       pos;
    int                       k;
    res = '0;
    blk_end = addr + len;
    n = free_used;
    pos = 0;

    // An entry at the same address counts as lying below the new block.
    while (pos < n && free_base[pos] <= addr) pos++;
    if (pos > 0) begin
      low_end = free_base[pos-1] + free_len[pos-1];
      res.below = (low_end == addr);
    end
    if (pos < n) begin
      res.above = (free_base[pos] == blk_end);
    end

    if (res.below && res.above) begin
      // Fold three blocks into the lower entry and close the gap above it.
      free_len[pos-1] = free_len[pos-1] + len + free_len[pos];
      for (k = pos; k + 1 < n; k++) begin
        free_base[k] = free_base[k+1];
        free_len[k]  = free_len[k+1];
      end
      n--;
    end else if (res.below) begin
      free_len[pos-1] = free_len[pos-1] + len;
    end else if (res.above) begin
      free_base[pos] = addr;
      free_len[pos]  = free_len[pos] + len;
    end else if (n >= TABLE_DEPTH) begin
      res.full = 1'b1;
    end else begin
      for (k = n; k > pos; k--) begin
        free_base[k] = free_base[k-1];
        free_len[k]  = free_len[k-1];
      end
      free_base[pos] = addr;
      free_len[pos]  = len;
      n++;
    end

    free_used = n;
    res.count = OUT_CNT_W'(n);
    return res;
  endfunction

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Result beats are checked before the input beat of the same edge is taken.
  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (!rst_n) begin
      free_used = 0;
      pending_outcomes.delete();
      mismatch_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.below = out_tdata[OUT_MB_BIT];
        got.above = out_tdata[OUT_MA_BIT];
        got.full  = out_tdata[OUT_FULL_BIT];
        got.count = out_tdata[OUT_CNT_LSB +: OUT_CNT_W];
        if (pending_outcomes.size() == 0) begin
          $display("%0t: result beat %h arrived with no block awaiting it",
                   $time, out_tdata);
          mismatch_count++;
        end else begin
          want = pending_outcomes.pop_front();
          compare_field("merged_below", want.below, got.below);
          compare_field("merged_above", want.above, got.above);
          compare_field("table_full", want.full, got.full);
          compare_field("entry_count", want.count, got.count);
        end
      end
      if (in_tvalid && in_tready) begin
        pending_outcomes.push_back(coalesce_block(in_tdata[ADDRESS_WIDTH-1:0],
                                                  in_tdata[2*ADDRESS_WIDTH-1:ADDRESS_WIDTH]));
      end
    end
    outstanding = pending_outcomes.size();
  end

endmodule

`default_nettype wire

// ===== test/coalescing_free_list_insert_core_test.sv =====
// Top of the coalescing free-list insert core test: clock, reset, freed-block
// stimulus and the verdict. Depends on cfli_pkg, the core and its checker.
`default_nettype none

module coalescing_free_list_insert_core_test;
  import cfli_pkg::*;

  localparam int IN_W         = ((2 * DEF_ADDRESS_WIDTH + 7) / 8) * 8;
  localparam int NUM_CHAINS   = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 1000000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic [IN_W-1:0]       in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  int                    mismatch_count;
  int                    outstanding;

  int                    tx_idle_pct;
  int                    rx_idle_pct;
  int                    items_sent;
  int                    hold_off_asked;
  int                    hold_off_served;
  int                    cycle_count;
  logic [31:0]           chain_top [NUM_CHAINS];

  coalescing_free_list_insert_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  coalescing_free_list_insert_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tdata       (in_tdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .out_tdata      (out_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the whole run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("coalescing_free_list_insert_core_test failed");
    $finish;
  end

  // Result side: random back-pressure, plus a long hold-off when asked for.
  initial begin
    out_tready = 1'b0;
    hold_off_served = 0;
    forever begin
      @(negedge clk);
      if (hold_off_asked != hold_off_served) begin
        hold_off_served++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offers one beat, starting and ending at a falling edge.
  task automatic push_block(input logic [31:0] addr, input logic [31:0] len);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata  <= {len, addr};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
  endtask

  // Carves the next stretch of a chain into pieces and frees them in random
  // order, so the pieces merge below, above and on both sides.
  task automatic send_arena(input int chain);
    logic [31:0] piece_addr [$];
    logic [31:0] piece_len [$];
    logic [31:0] cursor;
    logic [31:0] len;
    int          pick;
    cursor = chain_top[chain];
    repeat ($urandom_range(8, 2)) begin
      case ($urandom_range(19))
        0:             len = $urandom_range(1 << 20, 1);
        1, 2, 3, 4, 5: len = $urandom_range(4096, 1);
        default:       len = $urandom_range(64, 1);
      endcase
      piece_addr.push_back(cursor);
      piece_len.push_back(len);
      cursor = cursor + len;
    end
    chain_top[chain] = cursor;
    while (piece_addr.size() > 0) begin
      pick = $urandom_range(piece_addr.size() - 1);
      push_block(piece_addr[pick], piece_len[pick]);
      piece_addr.delete(pick);
      piece_len.delete(pick);
    end
  endtask

  // A block anywhere in the address space; these fill the table over time.
  task automatic send_stray();
    logic [31:0] addr;
    logic [31:0] len;
    addr = $urandom();
    case ($urandom_range(3))
      0:       len = $urandom();
      1:       len = $urandom_range(256, 1);
      2:       len = 32'hFFFF_FFFF - $urandom_range(255);
      default: len = -addr;  // ends exactly at the top of the address space
    endcase
    if (len == '0) len = 32'd1;
    push_block(addr, len);
  endtask

  task automatic run_random(input int upto, input int stray_pct);
    while (items_sent < upto) begin
      if ($urandom_range(99) < stray_pct) send_stray();
      else send_arena($urandom_range(NUM_CHAINS - 1));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    tx_idle_pct = 6;
    rx_idle_pct = 81;
    items_sent = 0;
    hold_off_asked = 0;
    for (int k = 0; k < NUM_CHAINS; k++) chain_top[k] = {k[3:0], 28'h0010000};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: insert, merge below, merge above, merge on both sides.
    push_block(32'h0000_1000, 32'h0000_0100);
    push_block(32'h0000_1100, 32'h0000_0080);
    push_block(32'h0000_0F00, 32'h0000_0100);
    push_block(32'h0000_2000, 32'h0000_0010);
    push_block(32'h0000_1180, 32'h0000_0E80);
    // Lowest address and size, then a block at an entry's own address.
    push_block(32'h0000_0000, 32'h0000_0001);
    push_block(32'h0000_0F00, 32'h0000_0040);
    push_block(32'h0000_0001, 32'h0000_0EFF);
    // Highest values, block ends past the top and a merged size that wraps.
    push_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_block(32'h5000_0000, 32'hFFFF_FFFF);
    push_block(32'h4FFF_FF00, 32'h0000_0100);
    push_block(32'hFFFF_FF00, 32'h0000_0200);
    push_block(32'h8000_0000, 32'h8000_0000);
    push_block(32'h7FFF_FFFF, 32'h0000_0001);
    push_block(32'h0000_0000, 32'hFFFF_FFFF);

    // Random: mostly carved chains, strays growing until the table fills.
    run_random(540, 2);
    tx_idle_pct = 81;
    rx_idle_pct = 6;
    run_random(1080, 4);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_off_asked++;
    run_random(1620, 25);
    in_tvalid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("coalescing_free_list_insert_core_test passed");
    end else begin
      $display("coalescing_free_list_insert_core_test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/cfli_pkg.sv
rtl/core/coalescing_free_list_insert_core.sv
rtl/core/cfli_checker.sv
test/coalescing_free_list_insert_checker.sv
test/coalescing_free_list_insert_core_test.sv
